@@ hdl/bacnet_tag_value_decoder_macros.svh @@
// assertion helpers
`ifndef BACNET_TAG_VALUE_DECODER_MACROS_SVH
`define BACNET_TAG_VALUE_DECODER_MACROS_SVH
`define BTVD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bacnet tag decoder check failed");
`define BTVD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bacnet tag decoder check failed");
`endif

@@ hdl/btvd_pkg.sv @@
package btvd_pkg;

  localparam int LENGTH_BITS = 32;

  typedef enum logic [2:0] {
    PH_HDR, PH_EXTTAG, PH_LENFIRST, PH_LENBYTES, PH_NUMERIC, PH_STRFIRST, PH_STRBODY
  } phase_t;

  typedef enum logic [1:0] {
    EV_HEADER = 2'd0, EV_VALUE = 2'd1, EV_CONTENT = 2'd2, EV_ERROR = 2'd3
  } event_t;

  typedef enum logic [3:0] {
    ERR_NONE = 4'd0, ERR_TRUNC = 4'd1, ERR_RESTAG = 4'd2, ERR_APPOC = 4'd3,
    ERR_CONTEXT = 4'd4, ERR_BOOL = 4'd5, ERR_LENGTH = 4'd6, ERR_DATETIME = 4'd7,
    ERR_BITSTR = 4'd8, ERR_UNSUP = 4'd9
  } err_t;

  localparam logic [7:0] TAG_NULL = 8'd0;
  localparam logic [7:0] TAG_BOOL = 8'd1;
  localparam logic [7:0] TAG_UNS = 8'd2;
  localparam logic [7:0] TAG_SIGNED = 8'd3;
  localparam logic [7:0] TAG_REAL = 8'd4;
  localparam logic [7:0] TAG_DOUBLE = 8'd5;
  localparam logic [7:0] TAG_OCTSTR = 8'd6;
  localparam logic [7:0] TAG_CHARSTR = 8'd7;
  localparam logic [7:0] TAG_BITSTR = 8'd8;
  localparam logic [7:0] TAG_ENUM = 8'd9;
  localparam logic [7:0] TAG_DATE = 8'd10;
  localparam logic [7:0] TAG_TIME = 8'd11;
  localparam logic [7:0] TAG_OBJID = 8'd12;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  tag_number;
    logic        is_context;
    logic        is_opening;
    logic        is_closing;
    logic [31:0] content_length;
    logic [2:0]  header_octets;
    logic [31:0] decoded_value;
    logic [7:0]  content_byte;
    logic        end_of_value;
    logic [3:0]  error_code;
  } out_item_t;

  // front-to-back queue status
  typedef struct packed {
    logic valid;
    logic ready;
  } link_t;

endpackage

@@ hdl/btvd_front.sv @@
module btvd_front
  import btvd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output in_item_t q_item,
  output link_t    q_link,
  input  logic     q_pop
);

  // two-entry queue of accepted octets
  in_item_t   mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = q_pop && (count != 2'd0);
  assign q_item  = mem[rd_ptr];
  assign q_link  = '{valid: count != 2'd0, ready: !full};

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ hdl/btvd_back.sv @@
module btvd_back
  import btvd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      value_mode,
  input  in_item_t  q_item,
  input  link_t     q_link,
  output logic      q_pop,
  output out_item_t res_item,
  output logic      res_valid,
  input  logic      res_pop
);

  phase_t      parse_phase, parse_phase_next;
  logic [7:0]  held_tag, held_tag_next;
  logic        held_class, held_class_next;
  logic [2:0]  held_type_field, held_type_field_next;
  logic [2:0]  length_bytes_left, length_bytes_left_next;
  logic [31:0] held_length, held_length_next;
  logic [31:0] content_left, content_left_next;
  logic [31:0] value_accumulator, value_accumulator_next;
  logic [7:0]  first_content, first_content_next;
  logic [2:0]  header_count, header_count_next;

  logic        emit_now;
  out_item_t   emit_item;
  logic        step;

  logic [7:0]  b;
  logic        last;

  // output register frees as soon as it is taken
  assign step  = q_link.valid && (!res_valid || res_pop);
  assign q_pop = step;
  assign b     = q_item.data_byte;
  assign last  = q_item.buffer_end;

  function automatic logic date_ok(logic [7:0] m, logic [7:0] d, logic [7:0] w);
    return (m == 8'd255 || (m >= 8'd1 && m <= 8'd14)) &&
           (d == 8'd255 || (d >= 8'd1 && d <= 8'd34)) &&
           (w == 8'd255 || (w >= 8'd1 && w <= 8'd7));
  endfunction

  function automatic logic time_ok(logic [7:0] h, logic [7:0] m, logic [7:0] s,
                                   logic [7:0] c);
    return (h == 8'd255 || h <= 8'd23) && (m == 8'd255 || m <= 8'd59) &&
           (s == 8'd255 || s <= 8'd59) && (c == 8'd255 || c <= 8'd99);
  endfunction

  always_comb begin
    logic [7:0]  tg;
    logic        cls;
    logic [2:0]  tf;
    logic [31:0] len;
    logic [2:0]  hc;
    logic        hdr_done;
    logic        fail_now;
    err_t        code;
    event_t      kind;
    logic [31:0] dv;
    logic [7:0]  cb;
    logic        eov;
    logic [31:0] acc;
    logic [31:0] cl;
    logic [31:0] sext;
    parse_phase_next       = parse_phase;
    held_tag_next          = held_tag;
    held_class_next        = held_class;
    held_type_field_next   = held_type_field;
    length_bytes_left_next = length_bytes_left;
    held_length_next       = held_length;
    content_left_next      = content_left;
    value_accumulator_next = value_accumulator;
    first_content_next     = first_content;
    header_count_next      = header_count;
    tg = held_tag;
    cls = held_class;
    tf = held_type_field;
    len = held_length;
    hc = header_count;
    hdr_done = 1'b0;
    fail_now = 1'b0;
    code = ERR_NONE;
    kind = EV_HEADER;
    dv = '0;
    cb = '0;
    eov = 1'b0;
    emit_now = 1'b0;
    acc = '0;
    cl = '0;
    sext = '0;

    unique case (parse_phase)
      PH_HDR: begin
        tg = {4'd0, b[7:4]};
        cls = b[3];
        tf = b[2:0];
        len = '0;
        hc = 3'd1;
        if (b[7:4] == 4'hF) begin
          if (last) begin
            fail_now = 1'b1; code = ERR_TRUNC;
          end else begin
            parse_phase_next = PH_EXTTAG;
          end
        end else if (tf == 3'd5) begin
          if (last) begin
            fail_now = 1'b1; code = ERR_TRUNC;
          end else begin
            parse_phase_next = PH_LENFIRST;
          end
        end else begin
          len = (tf <= 3'd4) ? {29'd0, tf} : 32'd0;
          hdr_done = 1'b1;
        end
      end
      PH_EXTTAG: begin
        hc = 3'd2;
        if (b == 8'd255) begin
          fail_now = 1'b1; code = ERR_RESTAG;
        end else begin
          tg = b;
          if (tf == 3'd5) begin
            if (last) begin
              fail_now = 1'b1; code = ERR_TRUNC;
            end else begin
              parse_phase_next = PH_LENFIRST;
            end
          end else begin
            len = (tf <= 3'd4) ? {29'd0, tf} : 32'd0;
            hdr_done = 1'b1;
          end
        end
      end
      PH_LENFIRST: begin
        hc = header_count + 3'd1;
        if (b <= 8'd253) begin
          len = {24'd0, b};
          hdr_done = 1'b1;
        end else begin
          length_bytes_left_next = (b == 8'd254) ? 3'd2 : 3'd4;
          len = '0;
          if (last) begin
            fail_now = 1'b1; code = ERR_TRUNC;
          end else begin
            parse_phase_next = PH_LENBYTES;
          end
        end
      end
      PH_LENBYTES: begin
        hc = header_count + 3'd1;
        len = {held_length[23:0], b};
        length_bytes_left_next = length_bytes_left - 3'd1;
        if (length_bytes_left == 3'd1) begin
          hdr_done = 1'b1;
        end else if (last) begin
          fail_now = 1'b1; code = ERR_TRUNC;
        end
      end
      PH_NUMERIC: begin
        if (content_left == held_length) first_content_next = b;
        acc = {value_accumulator[23:0], b};
        value_accumulator_next = acc;
        cl = content_left - 32'd1;
        content_left_next = cl;
        if (cl == 32'd0) begin
          // sign extension uses the first content octet
          if (held_tag == TAG_SIGNED && held_length < 32'd4 &&
              ((content_left == held_length) ? b[7] : first_content[7])) begin
            unique case (held_length[1:0])
              2'd1: sext = 32'hFFFFFF00;
              2'd2: sext = 32'hFFFF0000;
              2'd3: sext = 32'hFF000000;
              default: sext = 32'hFFFFFFFF;
            endcase
          end
          acc = acc | sext;
          if (held_tag == TAG_DATE && !date_ok(acc[23:16], acc[15:8], acc[7:0])) begin
            fail_now = 1'b1; code = ERR_DATETIME;
          end else if (held_tag == TAG_TIME &&
                       !time_ok(acc[31:24], acc[23:16], acc[15:8], acc[7:0])) begin
            fail_now = 1'b1; code = ERR_DATETIME;
          end else begin
            emit_now = 1'b1; kind = EV_VALUE; dv = acc;
            parse_phase_next = PH_HDR;
          end
        end else if (last) begin
          fail_now = 1'b1; code = ERR_TRUNC;
        end
      end
      PH_STRFIRST: begin
        first_content_next = b;
        cl = content_left - 32'd1;
        content_left_next = cl;
        if (held_tag == TAG_BITSTR && (b > 8'd7 || (cl == 32'd0 && b != 8'd0))) begin
          fail_now = 1'b1; code = ERR_BITSTR;
        end else if (cl == 32'd0) begin
          emit_now = 1'b1; kind = EV_VALUE; dv = {24'd0, b};
          parse_phase_next = PH_HDR;
        end else if (last) begin
          fail_now = 1'b1; code = ERR_TRUNC;
        end else begin
          parse_phase_next = PH_STRBODY;
        end
      end
      PH_STRBODY: begin
        if (content_left == 32'd0) begin
          fail_now = 1'b1; code = ERR_LENGTH;
        end else begin
          cl = content_left - 32'd1;
          content_left_next = cl;
          if (cl != 32'd0 && last) begin
            fail_now = 1'b1; code = ERR_TRUNC;
          end else begin
            emit_now = 1'b1; kind = EV_CONTENT;
            dv = {24'd0, first_content}; cb = b; eov = (cl == 32'd0);
            parse_phase_next = eov ? PH_HDR : PH_STRBODY;
          end
        end
      end
      default: begin
        parse_phase_next = PH_HDR;
      end
    endcase

    if (hdr_done) begin
      priority if ((tf == 3'd6 || tf == 3'd7) && !cls) begin
        fail_now = 1'b1; code = ERR_APPOC;
      end else if (!value_mode) begin
        emit_now = 1'b1; kind = EV_HEADER;
        parse_phase_next = PH_HDR;
      end else if (cls) begin
        fail_now = 1'b1; code = ERR_CONTEXT;
      end else begin
        unique case (tg)
          TAG_BOOL: begin
            if (tf > 3'd1) begin
              fail_now = 1'b1; code = ERR_BOOL;
            end else begin
              emit_now = 1'b1; kind = EV_VALUE; dv = {31'd0, tf[0]};
              parse_phase_next = PH_HDR;
            end
          end
          TAG_NULL: begin
            if (len != 32'd0) begin
              fail_now = 1'b1; code = ERR_LENGTH;
            end else begin
              emit_now = 1'b1; kind = EV_VALUE;
              parse_phase_next = PH_HDR;
            end
          end
          TAG_UNS, TAG_SIGNED, TAG_ENUM: begin
            if (len < 32'd1 || len > 32'd4) begin
              fail_now = 1'b1; code = ERR_LENGTH;
            end else if (last) begin
              fail_now = 1'b1; code = ERR_TRUNC;
            end else begin
              parse_phase_next = PH_NUMERIC;
            end
          end
          TAG_REAL, TAG_DATE, TAG_TIME, TAG_OBJID: begin
            if (len != 32'd4) begin
              fail_now = 1'b1; code = ERR_LENGTH;
            end else if (last) begin
              fail_now = 1'b1; code = ERR_TRUNC;
            end else begin
              parse_phase_next = PH_NUMERIC;
            end
          end
          TAG_OCTSTR: begin
            if (len == 32'd0) begin
              emit_now = 1'b1; kind = EV_VALUE;
              parse_phase_next = PH_HDR;
            end else if (last) begin
              fail_now = 1'b1; code = ERR_TRUNC;
            end else begin
              first_content_next = 8'd0;
              parse_phase_next = PH_STRBODY;
            end
          end
          TAG_CHARSTR, TAG_BITSTR: begin
            if (len == 32'd0) begin
              fail_now = 1'b1; code = ERR_LENGTH;
            end else if (last) begin
              fail_now = 1'b1; code = ERR_TRUNC;
            end else begin
              parse_phase_next = PH_STRFIRST;
            end
          end
          default: begin
            fail_now = 1'b1; code = ERR_UNSUP;
          end
        endcase
        if (!fail_now && !emit_now) begin
          content_left_next = len;
          value_accumulator_next = '0;
        end
      end
    end

    held_tag_next        = tg;
    held_class_next      = cls;
    held_type_field_next = tf;
    held_length_next     = len;
    header_count_next    = hc;

    emit_item = '0;
    if (fail_now) begin
      emit_item.event_kind = EV_ERROR;
      emit_item.error_code = code;
      parse_phase_next = PH_HDR;
    end else begin
      emit_item.event_kind     = kind;
      emit_item.tag_number     = tg;
      emit_item.is_context     = cls;
      emit_item.is_opening     = (tf == 3'd6);
      emit_item.is_closing     = (tf == 3'd7);
      emit_item.content_length = len;
      emit_item.header_octets  = hc;
      emit_item.decoded_value  = dv;
      emit_item.content_byte   = cb;
      emit_item.end_of_value   = eov;
    end
    emit_now = emit_now || fail_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_HDR;
      held_tag          <= '0;
      held_class        <= 1'b0;
      held_type_field   <= '0;
      length_bytes_left <= '0;
      held_length       <= '0;
      content_left      <= '0;
      value_accumulator <= '0;
      first_content     <= '0;
      header_count      <= '0;
      res_valid         <= 1'b0;
    end else begin
      if (step) begin
        parse_phase       <= parse_phase_next;
        held_tag          <= held_tag_next;
        held_class        <= held_class_next;
        held_type_field   <= held_type_field_next;
        length_bytes_left <= length_bytes_left_next;
        held_length       <= held_length_next;
        content_left      <= content_left_next;
        value_accumulator <= value_accumulator_next;
        first_content     <= first_content_next;
        header_count      <= header_count_next;
      end
      if (step && emit_now) res_valid <= 1'b1;
      else if (res_pop) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit_now) res_item <= emit_item;
  end

endmodule

@@ hdl/bacnet_tag_value_decoder.sv @@
// Streaming decoder for application-tagged primitives, one octet per request.
// Octets enter a two-deep queue; the decoder takes one octet per cycle from
// it while its result register is free and registers at most one result per
// octet, so with pop held high the block sustains one octet per clock. The
// rate is set by the single-octet parse step in the back stage. value_mode
// (reset 1) takes effect at the next header completion.
module bacnet_tag_value_decoder
  import btvd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_data
);

  logic     value_mode;
  in_item_t q_item;
  link_t    q_link;
  logic     q_pop;
  logic     res_valid;

  always_ff @(posedge clk) begin
    if (rst) value_mode <= 1'b1;
    else if (cfg_we) value_mode <= cfg_data;
  end

  btvd_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .q_item(q_item), .q_link(q_link), .q_pop(q_pop)
  );

  btvd_back u_back (
    .clk(clk), .rst(rst), .value_mode(value_mode), .q_item(q_item),
    .q_link(q_link), .q_pop(q_pop), .res_item(out_item), .res_valid(res_valid),
    .res_pop(pop && res_valid)
  );

  assign empty = !res_valid;

endmodule

@@ hdl/btvd_checker.sv @@
`include "bacnet_tag_value_decoder_macros.svh"
module btvd_checker
  import btvd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  `BTVD_ASSERT_IMPL(a_err_fields, !empty && out_item.event_kind == EV_ERROR, out_item.tag_number == 8'd0 && out_item.content_length == 32'd0 && out_item.error_code != ERR_NONE)
  `BTVD_ASSERT_IMPL(a_ok_code, !empty && out_item.event_kind != EV_ERROR, out_item.error_code == ERR_NONE && out_item.header_octets != 3'd0)
  `BTVD_ASSERT_IMPL(a_eov_kind, !empty && out_item.end_of_value, out_item.event_kind == EV_CONTENT)
  `BTVD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_item))

endmodule

bind bacnet_tag_value_decoder btvd_checker u_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .out_item(out_item)
);

@@ sim/bacnet_tag_value_decoder_checker.sv @@
`timescale 1ns / 100ps

module bacnet_tag_value_decoder_checker
  import btvd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_item_t  in_item,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_data,
  output int        fail_count,
  output int        pending
);

  // decoder state mirror
  logic        mode;
  phase_t      phase;
  logic [7:0]  tag;
  logic        cls;
  logic [2:0]  lvt;
  logic [2:0]  len_left;
  logic [31:0] len;
  logic [31:0] remaining;
  logic [31:0] acc;
  logic [7:0]  first_byte;
  logic [2:0]  hdr_count;

  out_item_t expected_events[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic out_item_t emit_event(input event_t kind, input logic [31:0] dv,
                                           input logic [7:0] cb, input logic eov);
    out_item_t r;
    r.event_kind = kind;
    r.tag_number = tag;
    r.is_context = cls;
    r.is_opening = (lvt == 3'd6);
    r.is_closing = (lvt == 3'd7);
    r.content_length = len;
    r.header_octets = hdr_count;
    r.decoded_value = dv;
    r.content_byte = cb;
    r.end_of_value = eov;
    r.error_code = ERR_NONE;
    phase = (kind == EV_CONTENT && !eov) ? PH_STRBODY : PH_HDR;
    expected_events.push_back(r);
    return r;
  endfunction

  function automatic void raise_error(input err_t code);
    out_item_t r;
    r = '0;
    r.event_kind = EV_ERROR;
    r.error_code = code;
    phase = PH_HDR;
    expected_events.push_back(r);
  endfunction

  function automatic bit field_ok(input logic [7:0] v, input int lo, input int hi);
    return v == 8'd255 || (v >= lo && v <= hi);
  endfunction

  function automatic void finish_header(input logic last);
    phase_t nxt;
    if ((lvt == 3'd6 || lvt == 3'd7) && !cls) begin
      raise_error(ERR_APPOC); return;
    end
    if (!mode) begin
      void'(emit_event(EV_HEADER, 0, 0, 0)); return;
    end
    if (cls) begin
      raise_error(ERR_CONTEXT); return;
    end
    unique case (tag)
      TAG_BOOL: begin
        if (lvt > 3'd1) raise_error(ERR_BOOL);
        else void'(emit_event(EV_VALUE, {29'd0, lvt}, 0, 0));
        return;
      end
      TAG_NULL: begin
        if (len != 0) raise_error(ERR_LENGTH);
        else void'(emit_event(EV_VALUE, 0, 0, 0));
        return;
      end
      TAG_UNS, TAG_SIGNED, TAG_ENUM: begin
        if (len < 1 || len > 4) begin
          raise_error(ERR_LENGTH); return;
        end
        nxt = PH_NUMERIC;
      end
      TAG_REAL, TAG_DATE, TAG_TIME, TAG_OBJID: begin
        if (len != 4) begin
          raise_error(ERR_LENGTH); return;
        end
        nxt = PH_NUMERIC;
      end
      TAG_OCTSTR: begin
        if (len == 0) begin
          void'(emit_event(EV_VALUE, 0, 0, 0)); return;
        end
        first_byte = 0;
        nxt = PH_STRBODY;
      end
      TAG_CHARSTR, TAG_BITSTR: begin
        if (len < 1) begin
          raise_error(ERR_LENGTH); return;
        end
        nxt = PH_STRFIRST;
      end
      default: begin
        raise_error(ERR_UNSUP); return;
      end
    endcase
    if (last) begin
      raise_error(ERR_TRUNC); return;
    end
    remaining = len;
    acc = 0;
    phase = nxt;
  endfunction

  function automatic void tag_done(input logic last);
    if (lvt == 3'd5) begin
      if (last) raise_error(ERR_TRUNC);
      else phase = PH_LENFIRST;
      return;
    end
    len = (lvt <= 3'd4) ? {29'd0, lvt} : 32'd0;
    finish_header(last);
  endfunction

  function automatic void decode_octet(input logic [7:0] b, input logic last);
    logic [31:0] a;
    unique case (phase)
      PH_HDR: begin
        tag = {4'd0, b[7:4]};
        cls = b[3];
        lvt = b[2:0];
        len = 0;
        hdr_count = 3'd1;
        if (tag == 8'd15) begin
          if (last) raise_error(ERR_TRUNC);
          else phase = PH_EXTTAG;
        end else tag_done(last);
      end
      PH_EXTTAG: begin
        hdr_count = 3'd2;
        if (b == 8'd255) raise_error(ERR_RESTAG);
        else begin
          tag = b;
          tag_done(last);
        end
      end
      PH_LENFIRST: begin
        hdr_count = hdr_count + 3'd1;
        if (b <= 8'd253) begin
          len = {24'd0, b};
          finish_header(last);
        end else begin
          len_left = (b == 8'd254) ? 3'd2 : 3'd4;
          len = 0;
          if (last) raise_error(ERR_TRUNC);
          else phase = PH_LENBYTES;
        end
      end
      PH_LENBYTES: begin
        hdr_count = hdr_count + 3'd1;
        len = {len[23:0], b};
        len_left = len_left - 3'd1;
        if (len_left == 0) finish_header(last);
        else if (last) raise_error(ERR_TRUNC);
      end
      PH_NUMERIC: begin
        if (remaining == len) first_byte = b;
        acc = {acc[23:0], b};
        remaining = remaining - 1;
        if (remaining == 0) begin
          a = acc;
          if (tag == TAG_SIGNED && len < 4 && first_byte[7])
            a = a | (32'hFFFF_FFFF << (8 * len));
          if (tag == TAG_DATE && !(field_ok(a[23:16], 1, 14) && field_ok(a[15:8], 1, 34)
                                   && field_ok(a[7:0], 1, 7)))
            raise_error(ERR_DATETIME);
          else if (tag == TAG_TIME && !(field_ok(a[31:24], 0, 23) &&
                   field_ok(a[23:16], 0, 59) && field_ok(a[15:8], 0, 59) &&
                   field_ok(a[7:0], 0, 99)))
            raise_error(ERR_DATETIME);
          else void'(emit_event(EV_VALUE, a, 0, 0));
        end else if (last) raise_error(ERR_TRUNC);
      end
      PH_STRFIRST: begin
        first_byte = b;
        remaining = remaining - 1;
        if (tag == TAG_BITSTR && (b > 8'd7 || (remaining == 0 && b != 0)))
          raise_error(ERR_BITSTR);
        else if (remaining == 0) void'(emit_event(EV_VALUE, {24'd0, b}, 0, 0));
        else if (last) raise_error(ERR_TRUNC);
        else phase = PH_STRBODY;
      end
      PH_STRBODY: begin
        if (remaining == 0) raise_error(ERR_LENGTH);
        else begin
          remaining = remaining - 1;
          if (remaining != 0 && last) raise_error(ERR_TRUNC);
          else void'(emit_event(EV_CONTENT, {24'd0, first_byte}, b, remaining == 0));
        end
      end
      default: phase = PH_HDR;
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      mode = 1'b1; phase = PH_HDR; tag = 0; cls = 0; lvt = 0; len_left = 0;
      len = 0; remaining = 0; acc = 0; first_byte = 0; hdr_count = 0;
      expected_events.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) mode = cfg_data;
      if (pop && !empty) begin
        if (expected_events.size() == 0) begin
          report("unexpected result", 32'(out_item.event_kind), 32'(EV_ERROR));
        end else begin
          want = expected_events.pop_front();
          if (out_item.event_kind !== want.event_kind)
            report("event_kind", 32'(out_item.event_kind), 32'(want.event_kind));
          if (out_item.tag_number !== want.tag_number)
            report("tag_number", 32'(out_item.tag_number), 32'(want.tag_number));
          if (out_item.is_context !== want.is_context)
            report("is_context", 32'(out_item.is_context), 32'(want.is_context));
          if (out_item.is_opening !== want.is_opening)
            report("is_opening", 32'(out_item.is_opening), 32'(want.is_opening));
          if (out_item.is_closing !== want.is_closing)
            report("is_closing", 32'(out_item.is_closing), 32'(want.is_closing));
          if (out_item.content_length !== want.content_length)
            report("content_length", out_item.content_length, want.content_length);
          if (out_item.header_octets !== want.header_octets)
            report("header_octets", 32'(out_item.header_octets), 32'(want.header_octets));
          if (out_item.decoded_value !== want.decoded_value)
            report("decoded_value", out_item.decoded_value, want.decoded_value);
          if (out_item.content_byte !== want.content_byte)
            report("content_byte", 32'(out_item.content_byte), 32'(want.content_byte));
          if (out_item.end_of_value !== want.end_of_value)
            report("end_of_value", 32'(out_item.end_of_value), 32'(want.end_of_value));
          if (out_item.error_code !== want.error_code)
            report("error_code", 32'(out_item.error_code), 32'(want.error_code));
        end
      end
      if (push && !full) decode_octet(in_item.data_byte, in_item.buffer_end);
    end
    pending = expected_events.size();
  end

endmodule

@@ sim/tb_bacnet_tag_value_decoder.sv @@
`timescale 1ns / 100ps

module tb_bacnet_tag_value_decoder;
  import btvd_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic      cfg_data = 1'b0;
  int        fail_count;
  int        pending;
  int        octets_sent;

  logic [7:0] msg[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bacnet_tag_value_decoder i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  bacnet_tag_value_decoder_checker i_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side stalls at random, with calm stretches
  initial begin
    int g;
    @(negedge clk);
    forever begin
      g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(negedge clk);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  task automatic send_octet(input logic [7:0] b, input logic last, input bit calm);
    int g;
    g = calm ? 0 : gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk);
    end
    push <= 1'b1;
    in_item <= '{data_byte: b, buffer_end: last};
    // full only moves at the rising edge, so it is settled here
    while (full) @(negedge clk);
    @(negedge clk);
    octets_sent++;
  endtask

  task automatic send_msg(input bit calm);
    foreach (msg[k]) send_octet(msg[k], (k == msg.size() - 1) ? 1'b1 : 1'b0, calm);
    msg.delete();
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // header for an application tag with given length
  task automatic add_header(input logic [7:0] t, input bit ctx, input int n);
    logic [7:0] first;
    first = {(t > 14) ? 4'hF : t[3:0], ctx, 3'd0};
    if (n <= 4) first[2:0] = n[2:0]; else first[2:0] = 3'd5;
    msg.push_back(first);
    if (t > 14) msg.push_back(t);
    if (n > 4) begin
      if (n <= 253) msg.push_back(n[7:0]);
      else begin
        msg.push_back(8'd254);
        msg.push_back(n[15:8]);
        msg.push_back(n[7:0]);
      end
    end
  endtask

  task automatic add_random_value();
    logic [7:0] t;
    int n;
    int pick;
    pick = $urandom_range(0, 13);
    unique case (pick)
      0: t = TAG_NULL;   1: t = TAG_BOOL;  2: t = TAG_UNS;    3: t = TAG_SIGNED;
      4: t = TAG_REAL;   5: t = TAG_OCTSTR; 6: t = TAG_CHARSTR; 7: t = TAG_BITSTR;
      8: t = TAG_ENUM;   9: t = TAG_DATE;  10: t = TAG_TIME;   11: t = TAG_OBJID;
      12: t = TAG_DOUBLE; default: t = 8'($urandom_range(13, 254));
    endcase
    if (t == TAG_BOOL) begin
      msg.push_back({4'd1, 1'b0, 3'($urandom_range(0, 1))});
      return;
    end
    unique case (t)
      TAG_NULL: n = 0;
      TAG_UNS, TAG_SIGNED, TAG_ENUM: n = $urandom_range(1, 4);
      TAG_OCTSTR, TAG_CHARSTR, TAG_BITSTR:
        n = ($urandom_range(0, 20) == 0) ? $urandom_range(254, 300) : $urandom_range(1, 8);
      default: n = 4;
    endcase
    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 6);
    add_header(t, 1'b0, n);
    for (int k = 0; k < n; k++) begin
      if (t == TAG_BITSTR && k == 0) msg.push_back(8'($urandom_range(0, 8)));
      else if (t == TAG_DATE && k > 0 && $urandom_range(0, 5) != 0)
        msg.push_back(8'((k == 3) ? $urandom_range(1, 7) : $urandom_range(1, 14)));
      else if (t == TAG_TIME && $urandom_range(0, 5) != 0)
        msg.push_back(8'($urandom_range(0, 23)));
      else msg.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    octets_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed values in decode mode
    add_header(TAG_UNS, 0, 1); msg.push_back(8'hFF); send_msg(1);
    add_header(TAG_SIGNED, 0, 2); msg.push_back(8'h80); msg.push_back(8'h00); send_msg(0);
    add_header(TAG_DATE, 0, 4); msg.push_back(8'h7B); msg.push_back(8'd14);
    msg.push_back(8'd255); msg.push_back(8'd8); send_msg(0);
    add_header(TAG_TIME, 0, 4); msg.push_back(8'd24); msg.push_back(0);
    msg.push_back(0); msg.push_back(0); send_msg(0);
    msg.push_back(8'h11); send_msg(0);            // boolean true
    msg.push_back(8'h15); msg.push_back(8'd9); send_msg(0);   // boolean extended
    msg.push_back(8'hF0); msg.push_back(8'hFF); send_msg(0);  // reserved tag
    msg.push_back(8'h0E); send_msg(0);            // context opening
    msg.push_back(8'h29); send_msg(0);            // context class
    msg.push_back(8'h65); msg.push_back(8'hFF); msg.push_back(8'hFF);
    msg.push_back(8'hFF); msg.push_back(8'hFF); msg.push_back(8'hFF); send_msg(0);
    add_header(TAG_BITSTR, 0, 1); msg.push_back(8'd3); send_msg(0);
    add_header(TAG_CHARSTR, 0, 3); msg.push_back(0); msg.push_back(8'h41);
    msg.push_back(8'hC3); send_msg(0);
    msg.push_back(8'h63); msg.push_back(8'hAA); msg.push_back(8'hBB); send_msg(0); // truncated
    add_header(TAG_OCTSTR, 0, 0); send_msg(0);

    set_mode(1'b0);
    msg.push_back(8'h3E); msg.push_back(8'h3F); msg.push_back(8'h0F);
    msg.push_back(8'hFD); msg.push_back(8'hFE); msg.push_back(8'hFE);
    msg.push_back(8'h00); msg.push_back(8'h01); send_msg(0);
    msg.push_back(8'h2D); msg.push_back(8'hFE); msg.push_back(8'h00); msg.push_back(8'hFF);
    msg.push_back(8'h3D); msg.push_back(8'hFF); msg.push_back(8'h01); msg.push_back(8'h02);
    msg.push_back(8'h03); msg.push_back(8'h04); send_msg(0);
    for (int k = 0; k < 150; k++)
      send_octet(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 0);

    set_mode(1'b1);
    while (octets_sent < 1950) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(0, 255)));
        send_msg($urandom_range(0, 3) == 0);
      end else begin
        add_random_value();
        // sometimes cut the buffer short
        if (msg.size() > 1 && $urandom_range(0, 7) == 0)
          msg = msg[0:$urandom_range(0, msg.size() - 2)];
        send_msg($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 120) == 0) drain();
      if ($urandom_range(0, 300) == 0) begin
        set_mode(1'b0);
        repeat (20) send_octet(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0, 0);
        set_mode(1'b1);
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/btvd_pkg.sv
hdl/btvd_front.sv
hdl/btvd_back.sv
hdl/bacnet_tag_value_decoder.sv
hdl/btvd_checker.sv
sim/bacnet_tag_value_decoder_checker.sv
sim/tb_bacnet_tag_value_decoder.sv
